### hdl/ppa_pkg.sv
package ppa_pkg;

  // Grid limits and register reset
  localparam int          MAX_SIDE_DEF  = 128;
  localparam int          SIDE_MIN      = 3;
  localparam logic [7:0]  GRID_SIDE_RST = 8'd100;

  // Neighbour counts reach 8
  localparam int CNT_W = 4;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // Cell encoding
  typedef enum logic [1:0] {
    SP_EMPTY = 2'd0,
    SP_PRED  = 2'd1,
    SP_PREY  = 2'd2,
    SP_PLANT = 2'd3
  } species_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CALC,
    ST_COPY,
    ST_DONE
  } state_t;

  // Generation rule from own species and neighbour counts
  function automatic species_t next_species(
    input species_t         cur,
    input logic [CNT_W-1:0] p,
    input logic [CNT_W-1:0] y,
    input logic [CNT_W-1:0] l
  );
    species_t res;
    res = SP_EMPTY;
    case (cur)
      SP_PRED: begin
        res = (y != '0) ? SP_PRED : SP_EMPTY;
      end
      SP_PREY: begin
        if (p != '0 && p < CNT_W'(3))   res = SP_EMPTY;
        else if (p > CNT_W'(2))         res = SP_PRED;
        else if (l != '0)               res = SP_PREY;
        else                            res = SP_EMPTY;
      end
      SP_PLANT: begin
        if (y == CNT_W'(1))             res = SP_EMPTY;
        else if (y > CNT_W'(1))         res = SP_PREY;
        else                            res = SP_PLANT;
      end
      default: begin
        if (y > p && y >= l && l != '0)       res = SP_PREY;
        else if (p >= y && p >= l && y != '0) res = SP_PRED;
        else if (l > y && l > p)              res = SP_PLANT;
        else                                  res = SP_EMPTY;
      end
    endcase
    return res;
  endfunction

endpackage

### hdl/ppa_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module ppa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/predator_prey_automaton_step_core.sv
// Channel | Ports                                   | Direction
// --------+-----------------------------------------+----------
// in      | in_valid, in_stall, in_op,              | in
//         | in_cell_index, in_cell_value            |
// out     | out_valid, out_stall, out_read_value,   | out
//         | out_index_error                         |
// cfg     | cfg_wr_en, cfg_wr_data (grid_side)      | in
//
// Write and unused op go ST_EXEC then ST_DONE; an in-range read adds ST_READ between.
// Step: each cell is read on the single read port of the live grid (own cell plus
// 8 neighbours) and its next species written to the new grid, then a copy sweep
// moves the new grid back one cell per cycle.
// The input side accepts only while the sequencer is idle; one result may wait in the
// output register, a second one holds the sequencer until it frees. Reset is sync.
module predator_prey_automaton_step_core #(
  parameter int MAX_SIDE = ppa_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [13:0] in_cell_index,
  input  logic [1:0]  in_cell_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_read_value,
  output logic        out_index_error
);

  import ppa_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int NW    = CW + 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = 14;
  localparam int XW    = (IW > CW) ? IW : CW;
  localparam int GW    = 8;
  localparam int EW    = (SW > GW) ? SW : GW;
  localparam logic [3:0] LAST_K = 4'd9;

  // Configuration register
  logic [7:0] grid_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
    end else if (cfg_wr_en) begin
      grid_side_r <= cfg_wr_data;
    end
  end

  // Effective side and cell count, latched at each transfer
  logic [EW-1:0]   gs_x;
  logic [SW-1:0]   side_eff;
  logic [CW-1:0]   cells_eff;

  always_comb begin
    gs_x = EW'(grid_side_r);
    if (gs_x < EW'(SIDE_MIN))      side_eff = SW'(SIDE_MIN);
    else if (gs_x > EW'(MAX_SIDE)) side_eff = SW'(MAX_SIDE);
    else                           side_eff = SW'(gs_x);
    cells_eff = CW'({{SW{1'b0}}, side_eff} * {{SW{1'b0}}, side_eff});
  end

  // Registers
  state_t           state_r, state_nxt;
  logic [1:0]       op_r;
  logic [XW-1:0]    idx_r;
  logic [1:0]       val_r;
  logic [SW-1:0]    side_r;
  logic [CW-1:0]    cells_r;
  logic [AW-1:0]    cell_r, cell_nxt;
  logic [3:0]       k_r, k_nxt;
  species_t         cur_r, cur_nxt;
  logic [CNT_W-1:0] p_r, p_nxt, y_r, y_nxt, l_r, l_nxt;
  logic [CW-1:0]    copy_idx_r, copy_idx_nxt;
  logic [AW-1:0]    copy_addr_r, copy_addr_nxt;
  logic             copy_vld_r, copy_vld_nxt;
  logic [1:0]       res_value_r, res_value_nxt;
  logic             res_err_r, res_err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_read_value_r, out_read_value_nxt;
  logic             out_index_error_r, out_index_error_nxt;

  // Memory ports
  logic          live_we, live_re, new_we, new_re;
  logic [AW-1:0] live_waddr, live_raddr, new_waddr, new_raddr;
  logic [1:0]    live_wdata, live_rdata, new_wdata, new_rdata;

  ppa_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .re    (live_re),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  ppa_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_new_ram (
    .clk   (clk),
    .we    (new_we),
    .waddr (new_waddr),
    .wdata (new_wdata),
    .re    (new_re),
    .raddr (new_raddr),
    .rdata (new_rdata)
  );

  // Neighbour address: cell +/- offset, wrapped once around the ring
  logic [SW:0]          nb_mag;
  logic                 nb_neg;
  logic signed [NW-1:0] nb_base, nb_off, nb_sum, nb_fix, cells_s;
  logic [AW-1:0]        nb_addr;

  always_comb begin
    nb_mag = '0;
    nb_neg = 1'b0;
    case (k_r)
      4'd1: begin nb_mag = (SW+1)'(1); end
      4'd2: begin nb_mag = (SW+1)'(1); nb_neg = 1'b1; end
      4'd3: begin nb_mag = (SW+1)'(side_r); end
      4'd4: begin nb_mag = (SW+1)'(side_r); nb_neg = 1'b1; end
      4'd5: begin nb_mag = (SW+1)'(side_r) + (SW+1)'(1); end
      4'd6: begin nb_mag = (SW+1)'(side_r) + (SW+1)'(1); nb_neg = 1'b1; end
      4'd7: begin nb_mag = (SW+1)'(side_r) - (SW+1)'(1); end
      4'd8: begin nb_mag = (SW+1)'(side_r) - (SW+1)'(1); nb_neg = 1'b1; end
      default: begin nb_mag = '0; end
    endcase
    nb_base = $signed({{(NW-AW){1'b0}}, cell_r});
    nb_off  = $signed(NW'(nb_mag));
    cells_s = $signed({1'b0, cells_r});
    nb_sum  = nb_neg ? (nb_base - nb_off) : (nb_base + nb_off);
    if (nb_sum < 0)             nb_fix = nb_sum + cells_s;
    else if (nb_sum >= cells_s) nb_fix = nb_sum - cells_s;
    else                        nb_fix = nb_sum;
    nb_addr = nb_fix[AW-1:0];
  end

  // Counts including the neighbour arriving this cycle
  logic [CNT_W-1:0] p_add, y_add, l_add;
  logic             idx_oor;
  logic             last_cell;

  assign p_add     = p_r + CNT_W'(live_rdata == SP_PRED);
  assign y_add     = y_r + CNT_W'(live_rdata == SP_PREY);
  assign l_add     = l_r + CNT_W'(live_rdata == SP_PLANT);
  assign idx_oor   = idx_r >= XW'(cells_r);
  assign last_cell = (CW'(cell_r) + CW'(1)) == cells_r;

  // Sequencer
  always_comb begin
    state_nxt           = state_r;
    cell_nxt            = cell_r;
    k_nxt               = k_r;
    cur_nxt             = cur_r;
    p_nxt               = p_r;
    y_nxt               = y_r;
    l_nxt               = l_r;
    copy_idx_nxt        = copy_idx_r;
    copy_addr_nxt       = copy_idx_r[AW-1:0];
    copy_vld_nxt        = 1'b0;
    res_value_nxt       = res_value_r;
    res_err_nxt         = res_err_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_read_value_nxt  = out_read_value_r;
    out_index_error_nxt = out_index_error_r;
    live_we             = 1'b0;
    live_waddr          = idx_r[AW-1:0];
    live_wdata          = val_r;
    live_re             = 1'b0;
    live_raddr          = idx_r[AW-1:0];
    new_we              = 1'b0;
    new_waddr           = cell_r;
    new_wdata           = next_species(cur_r, p_add, y_add, l_add);
    new_re              = 1'b0;
    new_raddr           = copy_idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_value_nxt = 2'd0;
        res_err_nxt   = 1'b0;
        case (op_r)
          OP_WRITE, OP_READ: begin
            if (idx_oor) begin
              res_err_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end else if (op_r == OP_WRITE) begin
              live_we   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              live_re   = 1'b1;
              state_nxt = ST_READ;
            end
          end
          OP_STEP: begin
            cell_nxt  = '0;
            k_nxt     = '0;
            p_nxt     = '0;
            y_nxt     = '0;
            l_nxt     = '0;
            state_nxt = ST_CALC;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_READ: begin
        res_value_nxt = live_rdata;
        state_nxt     = ST_DONE;
      end

      // One read per cycle until the last step: own cell, then the 8 neighbours
      ST_CALC: begin
        live_re    = (k_r != LAST_K);
        live_raddr = nb_addr;
        if (k_r == 4'd1) begin
          cur_nxt = species_t'(live_rdata);
        end else if (k_r != 4'd0) begin
          p_nxt = p_add;
          y_nxt = y_add;
          l_nxt = l_add;
        end
        if (k_r == LAST_K) begin
          new_we = 1'b1;
          k_nxt  = '0;
          p_nxt  = '0;
          y_nxt  = '0;
          l_nxt  = '0;
          if (last_cell) begin
            copy_idx_nxt = '0;
            state_nxt    = ST_COPY;
          end else begin
            cell_nxt = cell_r + AW'(1);
          end
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end

      // Copy new grid back, each write in the cycle after its read
      ST_COPY: begin
        if (copy_idx_r != cells_r) begin
          new_re       = 1'b1;
          copy_vld_nxt = 1'b1;
          copy_idx_nxt = copy_idx_r + CW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
        if (copy_vld_r) begin
          live_we    = 1'b1;
          live_waddr = copy_addr_r;
          live_wdata = new_rdata;
        end
        res_value_nxt = 2'd0;
        res_err_nxt   = 1'b0;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_read_value_nxt  = res_value_r;
          out_index_error_nxt = res_err_r;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      copy_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      copy_vld_r  <= copy_vld_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_op;
      idx_r   <= XW'(in_cell_index);
      val_r   <= in_cell_value;
      side_r  <= side_eff;
      cells_r <= cells_eff;
    end
    cell_r            <= cell_nxt;
    k_r               <= k_nxt;
    cur_r             <= cur_nxt;
    p_r               <= p_nxt;
    y_r               <= y_nxt;
    l_r               <= l_nxt;
    copy_idx_r        <= copy_idx_nxt;
    copy_addr_r       <= copy_addr_nxt;
    res_value_r       <= res_value_nxt;
    res_err_r         <= res_err_nxt;
    out_read_value_r  <= out_read_value_nxt;
    out_index_error_r <= out_index_error_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_index_error = out_index_error_r;

  // Checks
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (k_r <= LAST_K))
    else $error("neighbour counter out of range");

  a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (CW'(cell_r) < cells_r))
    else $error("sweep cell beyond grid");

  a_live_write: assert property (@(posedge clk) disable iff (!rst_n)
    live_we |-> (state_r == ST_EXEC || state_r == ST_COPY))
    else $error("live grid written outside write op or copy");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("transfer did not start execution");

endmodule

### verif/predator_prey_automaton_step_core_test.sv
`timescale 1ns / 1ps

module predator_prey_automaton_step_core_test;
  import ppa_pkg::*;

  localparam int MAX_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
  // Slowest step (largest grid) plus the longest bursts of idling, four times over
  localparam int WATCHDOG_LIMIT = 4 * (11 * MAX_CELLS + 3 + 2 * 14);
  // Op code that the block treats as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [13:0] idx;
    logic [1:0]  val;
    bit          drain;
  } cell_op_t;

  typedef struct packed {
    logic [1:0] read_value;
    logic       index_error;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [13:0] in_cell_index = '0;
  logic [1:0]  in_cell_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_read_value;
  logic        out_index_error;

  // Pending input ops and results still owed by the block
  cell_op_t     queued_ops[$];
  cell_result_t awaited_results[$];

  // Grid model, effective side and which cells the stimulus has loaded
  species_t    grid_model [MAX_CELLS];
  species_t    next_gen [MAX_CELLS];
  bit          loaded [MAX_CELLS];
  int unsigned side_eff = GRID_SIDE_RST;

  species_t seed_pattern [9] = '{SP_PRED, SP_PREY, SP_PREY, SP_PLANT, SP_EMPTY,
                                 SP_PLANT, SP_PREY, SP_EMPTY, SP_PLANT};

  bit          idling_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  cell_op_t    next_op;
  cell_result_t owed;

  predator_prey_automaton_step_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_cell_index   (in_cell_index),
    .in_cell_value   (in_cell_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_index_error (out_index_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned saturate_side(input logic [7:0] v);
    if (v < SIDE_MIN) return SIDE_MIN;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return v;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Fate of one cell given its own species and the neighbour tallies
  function automatic species_t evolve_cell(input species_t self, input int p,
                                           input int y, input int l);
    species_t nxt;
    nxt = SP_EMPTY;
    case (self)
      SP_PRED: begin
        if (y > 0) nxt = SP_PRED;
      end
      SP_PREY: begin
        if (p > 2) nxt = SP_PRED;
        else if (p == 0 && l > 0) nxt = SP_PREY;
      end
      SP_PLANT: begin
        if (y > 1) nxt = SP_PREY;
        else if (y == 0) nxt = SP_PLANT;
      end
      default: begin
        if (y > p && y >= l && l > 0) nxt = SP_PREY;
        else if (p >= y && p >= l && y > 0) nxt = SP_PRED;
        else if (l > y && l > p) nxt = SP_PLANT;
      end
    endcase
    return nxt;
  endfunction

  // Whole-grid generation on the flat ring
  function automatic void advance_generation();
    int cells, s, i, k, j;
    int deltas [8];
    int tally [4];
    cells = side_eff * side_eff;
    s = side_eff;
    deltas = '{1, -1, s, -s, s + 1, -(s + 1), s - 1, -(s - 1)};
    for (i = 0; i < cells; i++) begin
      tally = '{0, 0, 0, 0};
      for (k = 0; k < 8; k++) begin
        j = (i + cells + deltas[k]) % cells;
        tally[grid_model[j]]++;
      end
      next_gen[i] = evolve_cell(grid_model[i], tally[SP_PRED], tally[SP_PREY],
                                tally[SP_PLANT]);
    end
    for (i = 0; i < cells; i++) grid_model[i] = next_gen[i];
  endfunction

  // Update the grid model for one accepted op and record the result it owes
  function automatic void apply_to_grid_model(input logic [1:0] op,
                                              input logic [13:0] idx,
                                              input logic [1:0] val);
    cell_result_t r;
    int unsigned cells;
    r = '0;
    cells = side_eff * side_eff;
    if (op == OP_WRITE || op == OP_READ) begin
      if (idx >= cells) r.index_error = 1'b1;
      else if (op == OP_WRITE) grid_model[idx] = species_t'(val);
      else r.read_value = grid_model[idx];
    end else if (op == OP_STEP) begin
      advance_generation();
    end
    awaited_results.push_back(r);
  endfunction

  // Driver: presents queued ops, random gaps between them while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_to_grid_model(in_op, in_cell_index, in_cell_value);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_ops.size() > 0 &&
                     !(queued_ops[0].drain && awaited_results.size() > 0)) begin
          next_op = queued_ops.pop_front();
          in_valid      <= 1'b1;
          in_op         <= next_op.op;
          in_cell_index <= next_op.idx;
          in_cell_value <= next_op.val;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation and drives random output stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result: read_value=%0d index_error=%0d",
                                 out_read_value, out_index_error));
        end else begin
          owed = awaited_results.pop_front();
          if (out_read_value !== owed.read_value || out_index_error !== owed.index_error)
            note_failure($sformatf({"result mismatch: expected read_value=%0d ",
                                    "index_error=%0d, got read_value=%0d index_error=%0d"},
                                   owed.read_value, owed.index_error,
                                   out_read_value, out_index_error));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idling_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] op, input int unsigned idx,
                            input logic [1:0] val, input bit drain);
    cell_op_t it;
    it.op = op;
    it.idx = idx[13:0];
    it.val = val;
    it.drain = drain;
    if (op == OP_WRITE && idx < side_eff * side_eff) loaded[idx] = 1'b1;
    queued_ops.push_back(it);
  endtask

  function automatic bit grid_fully_loaded();
    int unsigned i;
    for (i = 0; i < side_eff * side_eff; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Load every cell of the current grid that was never written
  task automatic fill_unloaded();
    int unsigned i;
    for (i = 0; i < side_eff * side_eff; i++)
      if (!loaded[i]) queue_item(OP_WRITE, i, 2'($urandom_range(0, 3)), 1'b0);
  endtask

  task automatic wait_quiet();
    while (queued_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  // Register write, only with the block idle
  task automatic set_side(input logic [7:0] v);
    wait_quiet();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_eff = saturate_side(v);
    @(negedge clk);
  endtask

  task automatic queue_random_item();
    int unsigned cells, pick, idx;
    logic [1:0] val;
    bit drain;
    cells = side_eff * side_eff;
    pick  = $urandom_range(0, 99);
    idx   = $urandom_range(0, cells - 1);
    val   = 2'($urandom_range(0, 3));
    drain = ($urandom_range(0, 19) == 0);
    if (pick < 40) begin
      queue_item(OP_WRITE, idx, val, drain);
    end else if (pick < 72) begin
      if (loaded[idx]) queue_item(OP_READ, idx, val, drain);
      else queue_item(OP_WRITE, idx, val, drain);
    end else if (pick < 84) begin
      if (grid_fully_loaded()) queue_item(OP_STEP, $urandom_range(0, 16383), val, drain);
      else queue_item(OP_WRITE, idx, val, drain);
    end else if (pick < 90 || cells >= MAX_CELLS) begin
      queue_item(OP_UNUSED, $urandom_range(0, 16383), val, drain);
    end else begin
      // index past the end of the grid
      idx = $urandom_range(cells, 16383);
      queue_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, idx, val, drain);
    end
  endtask

  initial begin
    int unsigned k, ph;
    logic [7:0] v;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset side: last valid index, first invalid one, all-ones index, unused op
    queue_item(OP_WRITE, 0, SP_PLANT, 1'b0);
    queue_item(OP_WRITE, 9999, SP_PRED, 1'b0);
    queue_item(OP_WRITE, 10000, SP_PREY, 1'b0);
    queue_item(OP_WRITE, 16383, SP_PLANT, 1'b0);
    queue_item(OP_READ, 0, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 9999, SP_PLANT, 1'b0);
    queue_item(OP_READ, 10000, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 16383, SP_PLANT, 1'b0);
    queue_item(OP_UNUSED, 16383, SP_PLANT, 1'b0);
    queue_item(OP_WRITE, 0, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 0, SP_EMPTY, 1'b1);

    // Side below range saturates to 3: every cell neighbours every other
    set_side(8'd1);
    for (k = 0; k < 9; k++) queue_item(OP_WRITE, k, seed_pattern[k], 1'b0);
    queue_item(OP_STEP, 0, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 0, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 1, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 3, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 4, SP_EMPTY, 1'b0);
    queue_item(OP_STEP, 16383, SP_PLANT, 1'b0);
    queue_item(OP_READ, 8, SP_EMPTY, 1'b0);

    // Side above range saturates to the largest grid; the far corner is in range
    set_side(8'd255);
    queue_item(OP_WRITE, 16383, SP_PREY, 1'b0);
    queue_item(OP_READ, 16383, SP_EMPTY, 1'b0);
    set_side(8'd128);
    queue_item(OP_READ, 16383, SP_EMPTY, 1'b0);
    queue_item(OP_READ, 0, SP_EMPTY, 1'b0);

    // Random phases on small grids, the last one without idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: v = 8'd0;
        1: v = 8'd2;
        2: v = 8'($urandom_range(4, 5));
        default: v = 8'($urandom_range(6, 7));
      endcase
      if (ph == 3) idling_on = 1'b0;
      set_side(v);
      fill_unloaded();
      for (k = 0; k < 10; k++) queue_random_item();
    end

    wait_quiet();
    repeat (20) @(negedge clk);
    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### predator_prey_automaton_step_core.f
hdl/ppa_pkg.sv
hdl/ppa_ram.sv
hdl/predator_prey_automaton_step_core.sv
verif/predator_prey_automaton_step_core_test.sv
